/* rtl/tlbm_pkg.sv */
// shared constants and types for the paging translator
`timescale 1ns / 1ps
package tlbm_pkg;

  localparam int TLBM_TLB_ENTRIES = 16;
  localparam int TLBM_PAGE_COUNT  = 256;
  localparam int TLBM_FRAME_COUNT = 128;
  localparam int TLBM_PAGE_BYTES  = 256;

  localparam int TLBM_VA_W  = 16;
  localparam int TLBM_PA_W  = 15;
  localparam int TLBM_EVP_W = 8;

  // commands from the sequencer to the tlb
  typedef struct packed {
    logic touch_en;  // make the hit entry most recent
    logic ins_en;    // write an entry and make it most recent
    logic inval_en;  // drop any entry holding the evicted page
  } tlbm_cmd_t;

endpackage

/* rtl/tlbm_tlb.sv */
// translation buffer: entries, parallel match, lru ranks, insert and invalidate
`timescale 1ns / 1ps
module tlbm_tlb import tlbm_pkg::*; #(
  parameter int TLB_ENTRIES = TLBM_TLB_ENTRIES,
  parameter int PAGE_W      = 8,
  parameter int FRAME_W     = 7,
  localparam int TLB_W      = $clog2(TLB_ENTRIES)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tlbm_cmd_t          cmd,
  input  logic [PAGE_W-1:0]  look_page,
  output logic               hit,
  output logic [FRAME_W-1:0] hit_frame,
  output logic               free,
  output logic [TLB_W-1:0]   free_slot,
  input  logic [TLB_W-1:0]   ins_slot,
  input  logic [PAGE_W-1:0]  ins_page,
  input  logic [FRAME_W-1:0] ins_frame,
  input  logic [PAGE_W-1:0]  inval_page,
  input  logic [TLB_W-1:0]   rd_idx,
  output logic [TLB_W-1:0]   rank_q
);

  logic [PAGE_W-1:0]  pg_r  [TLB_ENTRIES];
  logic [FRAME_W-1:0] fr_r  [TLB_ENTRIES];
  logic [TLB_W-1:0]   rk_r  [TLB_ENTRIES];
  logic [TLB_W-1:0]   rk_nxt[TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0] vld_r, vld_nxt;
  logic [TLB_W-1:0]   hit_slot, tch_slot, tch_old;
  logic               tch_en;
  logic [TLB_W-1:0]   rank_q_r;

  // priority encoders for the matching entry and the first empty entry
  always_comb begin
    hit       = 1'b0;
    hit_slot  = '0;
    free      = 1'b0;
    free_slot = '0;
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      if (!hit && vld_r[i] && pg_r[i] == look_page) begin
        hit      = 1'b1;
        hit_slot = TLB_W'(i);
      end
      if (!free && !vld_r[i]) begin
        free      = 1'b1;
        free_slot = TLB_W'(i);
      end
    end
  end

  assign hit_frame = fr_r[hit_slot];

  // rank update: entries above the old rank move down, the touched one goes to the top
  always_comb begin
    tch_en   = cmd.touch_en | cmd.ins_en;
    tch_slot = cmd.ins_en ? ins_slot : hit_slot;
    tch_old  = rk_r[tch_slot];
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      rk_nxt[i] = rk_r[i];
      if (tch_en) begin
        if (TLB_W'(i) == tch_slot) begin
          rk_nxt[i] = TLB_W'(TLB_ENTRIES - 1);
        end else if (rk_r[i] > tch_old) begin
          rk_nxt[i] = rk_r[i] - 1'b1;
        end
      end
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      if (cmd.inval_en && vld_r[i] && pg_r[i] == inval_page) begin
        vld_nxt[i] = 1'b0;
      end
      if (cmd.ins_en && TLB_W'(i) == ins_slot) begin
        vld_nxt[i] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      for (int i = 0; i < TLB_ENTRIES; i++) begin
        rk_r[i] <= '0;
      end
    end else begin
      vld_r <= vld_nxt;
      for (int i = 0; i < TLB_ENTRIES; i++) begin
        rk_r[i] <= rk_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ins_en) begin
      pg_r[ins_slot] <= ins_page;
      fr_r[ins_slot] <= ins_frame;
    end
    rank_q_r <= rk_r[rd_idx];
  end

  assign rank_q = rank_q_r;

endmodule

/* rtl/tlbm_min_unit.sv */
// shared compare unit: keeps the lowest rank seen in a sweep, lowest index on a tie
`timescale 1ns / 1ps
module tlbm_min_unit #(
  parameter int IDX_W = 8,
  parameter int RK_W  = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             dv,
  input  logic [IDX_W-1:0] idx,
  input  logic [RK_W-1:0]  rank,
  output logic [IDX_W-1:0] best_idx
);

  logic             found_r;
  logic [IDX_W-1:0] best_idx_r;
  logic [RK_W-1:0]  best_rk_r;
  logic             take;

  assign take = dv && (!found_r || rank < best_rk_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (start) begin
      found_r <= 1'b0;
    end else if (take) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_idx_r <= idx;
      best_rk_r  <= rank;
    end
  end

  assign best_idx = best_idx_r;

endmodule

/* rtl/tlb_mmu_with_frame_replacement_core.sv */
// top level: sequencer, page table, frame owner and frame rank memories
`timescale 1ns / 1ps
// Translates a virtual address (page in the high bits, offset in the low) through an lru tlb,
// a page table and a frame allocator with lru or fifo victims (cfg_data: 0 lru, 1 fifo), one
// result per address. One address is in flight at a time. The frame rank memory has one read
// and one write port, and each access walks all FRAME_COUNT ranks once to update them; an lru
// eviction first walks them through the shared compare unit to pick the victim frame. A table
// hit or a fault then inserts the page into the tlb, sweeping the tlb ranks through the compare
// unit for a victim slot when no slot is free. A fault takes the frames in turn, and once all are
// used a fifo eviction keeps taking them in turn. The result waits in its register while the
// previous one has not been taken; a new address is accepted after the result is registered.
// After reset a clearing pass over the page table and the frame ranks runs before the first
// address is taken; configuration writes are taken at any time.
module tlb_mmu_with_frame_replacement_core import tlbm_pkg::*; #(
  parameter int TLB_ENTRIES = TLBM_TLB_ENTRIES,
  parameter int PAGE_COUNT  = TLBM_PAGE_COUNT,
  parameter int FRAME_COUNT = TLBM_FRAME_COUNT,
  parameter int PAGE_BYTES  = TLBM_PAGE_BYTES
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [TLBM_VA_W-1:0]  in_virtual_address,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [TLBM_PA_W-1:0]  out_physical_address,
  output logic                  out_tlb_hit,
  output logic                  out_table_hit,
  output logic                  out_page_fault,
  output logic                  out_evicted_valid,
  output logic [TLBM_EVP_W-1:0] out_evicted_page,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_data
);

  localparam int PAGE_W  = $clog2(PAGE_COUNT);
  localparam int FRAME_W = $clog2(FRAME_COUNT);
  localparam int OFF_W   = $clog2(PAGE_BYTES);
  localparam int TLB_W   = $clog2(TLB_ENTRIES);
  localparam int SW_MAX  = (FRAME_COUNT > TLB_ENTRIES) ? FRAME_COUNT : TLB_ENTRIES;
  localparam int SW_W    = $clog2(SW_MAX + 1);
  localparam int RK_W    = (FRAME_W > TLB_W) ? FRAME_W : TLB_W;
  localparam int CLR_N   = (PAGE_COUNT > FRAME_COUNT) ? PAGE_COUNT : FRAME_COUNT;
  localparam int CLR_W   = $clog2(CLR_N + 1);

  localparam logic [3:0] ST_CLR   = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_LOOK  = 4'd2;
  localparam logic [3:0] ST_FMIN  = 4'd3;
  localparam logic [3:0] ST_EVRD  = 4'd4;
  localparam logic [3:0] ST_EVPT  = 4'd5;
  localparam logic [3:0] ST_EVCHK = 4'd6;
  localparam logic [3:0] ST_UPD   = 4'd7;
  localparam logic [3:0] ST_RRD   = 4'd8;
  localparam logic [3:0] ST_RWAIT = 4'd9;
  localparam logic [3:0] ST_TOUCH = 4'd10;
  localparam logic [3:0] ST_TLBF  = 4'd11;
  localparam logic [3:0] ST_TMIN  = 4'd12;
  localparam logic [3:0] ST_DONE  = 4'd13;

  logic [3:0]           state_r, state_nxt;
  logic [CLR_W-1:0]     clr_i_r;
  logic [TLBM_VA_W-1:0] va_r;
  logic [FRAME_W-1:0]   frame_r, oldr_r, nf_r;
  logic                 hit_r, thit_r, fault_r, evv_r, ins_r;
  logic [PAGE_W-1:0]    evp_r;
  logic                 full_r, mode_r;
  logic [SW_W-1:0]      sw_i_r, sw_di_r, sw_n;
  logic                 sw_dv_r, sw_issue, sw_done;
  logic                 out_valid_r;
  logic [TLBM_PA_W-1:0] out_pa_r;
  logic                 out_hit_r, out_thit_r, out_fault_r, out_evv_r;
  logic [TLBM_EVP_W-1:0] out_evp_r;

  logic [31:0]          in_sh, va_sh, pa32, evp32;
  logic [PAGE_W-1:0]    page_in, page_r;
  logic [FRAME_W+OFF_W-1:0] pa_full;

  // page table word: valid bit on top of the frame number
  logic [FRAME_W:0]     pt_mem [PAGE_COUNT];
  logic [FRAME_W:0]     pt_q_r, pt_wd;
  logic [PAGE_W-1:0]    pt_ra, pt_wa;
  logic                 pt_we;
  logic [PAGE_W-1:0]    ow_mem [FRAME_COUNT];
  logic [PAGE_W-1:0]    ow_q_r;
  logic                 ow_we;
  logic [FRAME_W-1:0]   rk_mem [FRAME_COUNT];
  logic [FRAME_W-1:0]   rk_q_r, rk_ra, rk_wa, rk_wd, sw_fidx;
  logic                 rk_we;

  tlbm_cmd_t            tlb_cmd;
  logic                 tlb_hit, tlb_free;
  logic [FRAME_W-1:0]   tlb_frame;
  logic [TLB_W-1:0]     tlb_free_slot, tlb_ins_slot, tlb_rd_idx, tlb_rank_q;
  logic                 min_start, min_dv;
  logic [RK_W-1:0]      min_rank;
  logic [SW_W-1:0]      min_best;

  assign in_sh   = 32'(in_virtual_address) >> OFF_W;
  assign page_in = in_sh[PAGE_W-1:0];
  assign va_sh   = 32'(va_r) >> OFF_W;
  assign page_r  = va_sh[PAGE_W-1:0];
  assign pa_full = {frame_r, va_r[OFF_W-1:0]};
  assign pa32    = 32'(pa_full);
  assign evp32   = 32'(evp_r);
  assign sw_fidx = sw_di_r[FRAME_W-1:0];

  assign sw_n     = (state_r == ST_TMIN) ? SW_W'(TLB_ENTRIES) : SW_W'(FRAME_COUNT);
  assign sw_issue = (sw_i_r != sw_n);
  assign sw_done  = !sw_issue && !sw_dv_r;

  tlbm_tlb #(
    .TLB_ENTRIES (TLB_ENTRIES),
    .PAGE_W      (PAGE_W),
    .FRAME_W     (FRAME_W)
  ) u_tlb (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (tlb_cmd),
    .look_page  (page_r),
    .hit        (tlb_hit),
    .hit_frame  (tlb_frame),
    .free       (tlb_free),
    .free_slot  (tlb_free_slot),
    .ins_slot   (tlb_ins_slot),
    .ins_page   (page_r),
    .ins_frame  (frame_r),
    .inval_page (ow_q_r),
    .rd_idx     (tlb_rd_idx),
    .rank_q     (tlb_rank_q)
  );

  tlbm_min_unit #(
    .IDX_W (SW_W),
    .RK_W  (RK_W)
  ) u_min (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (min_start),
    .dv       (min_dv),
    .idx      (sw_di_r),
    .rank     (min_rank),
    .best_idx (min_best)
  );

  assign min_rank = (state_r == ST_TMIN) ? RK_W'(tlb_rank_q) : RK_W'(rk_q_r);

  always_comb begin
    state_nxt    = state_r;
    in_ready     = 1'b0;
    pt_ra        = page_in;
    pt_we        = 1'b0;
    pt_wa        = page_r;
    pt_wd        = {1'b1, frame_r};
    ow_we        = 1'b0;
    rk_ra        = frame_r;
    rk_we        = 1'b0;
    rk_wa        = sw_fidx;
    rk_wd        = '0;
    tlb_cmd      = '0;
    tlb_ins_slot = tlb_free_slot;
    tlb_rd_idx   = sw_i_r[TLB_W-1:0];
    min_start    = 1'b0;
    min_dv       = 1'b0;
    case (state_r)
      ST_CLR: begin
        pt_we = (clr_i_r < CLR_W'(PAGE_COUNT));
        pt_wa = clr_i_r[PAGE_W-1:0];
        pt_wd = '0;
        rk_we = (clr_i_r < CLR_W'(FRAME_COUNT));
        rk_wa = clr_i_r[FRAME_W-1:0];
        rk_wd = '0;
        if (clr_i_r == CLR_W'(CLR_N - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (tlb_hit) begin
          tlb_cmd.touch_en = 1'b1;
          state_nxt        = ST_RRD;
        end else if (pt_q_r[FRAME_W]) begin
          state_nxt = ST_RRD;
        end else if (!full_r || mode_r) begin
          state_nxt = full_r ? ST_EVRD : ST_UPD;
        end else begin
          min_start = 1'b1;
          state_nxt = ST_FMIN;
        end
      end
      ST_FMIN: begin
        min_dv = sw_dv_r;
        rk_ra  = sw_i_r[FRAME_W-1:0];
        if (sw_done) begin
          state_nxt = ST_EVRD;
        end
      end
      ST_EVRD: begin
        state_nxt = ST_EVPT;
      end
      ST_EVPT: begin
        pt_ra            = ow_q_r;
        tlb_cmd.inval_en = 1'b1;
        state_nxt        = ST_EVCHK;
      end
      ST_EVCHK: begin
        // the owner loses its mapping only if it still points at this frame
        if (pt_q_r[FRAME_W] && pt_q_r[FRAME_W-1:0] == frame_r) begin
          pt_we = 1'b1;
          pt_wa = evp_r;
          pt_wd = '0;
        end
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        pt_we     = 1'b1;
        ow_we     = 1'b1;
        state_nxt = ST_RRD;
      end
      ST_RRD: begin
        state_nxt = ST_RWAIT;
      end
      ST_RWAIT: begin
        state_nxt = ST_TOUCH;
      end
      ST_TOUCH: begin
        // read one rank ahead, write back the one returned last cycle
        rk_ra = sw_i_r[FRAME_W-1:0];
        rk_we = sw_dv_r;
        if (sw_fidx == frame_r) begin
          rk_wd = FRAME_W'(FRAME_COUNT - 1);
        end else if (rk_q_r > oldr_r) begin
          rk_wd = rk_q_r - 1'b1;
        end else begin
          rk_wd = rk_q_r;
        end
        if (sw_done) begin
          state_nxt = ins_r ? ST_TLBF : ST_DONE;
        end
      end
      ST_TLBF: begin
        if (tlb_free) begin
          tlb_cmd.ins_en = 1'b1;
          state_nxt      = ST_DONE;
        end else begin
          min_start = 1'b1;
          state_nxt = ST_TMIN;
        end
      end
      ST_TMIN: begin
        min_dv = sw_dv_r;
        if (sw_done) begin
          tlb_cmd.ins_en = 1'b1;
          tlb_ins_slot   = min_best[TLB_W-1:0];
          state_nxt      = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_i_r     <= '0;
      mode_r      <= 1'b0;
      full_r      <= 1'b0;
      nf_r        <= '0;
      out_valid_r <= 1'b0;
      sw_i_r      <= '0;
      sw_dv_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        mode_r <= cfg_data;
      end
      if (state_r == ST_CLR) begin
        clr_i_r <= clr_i_r + 1'b1;
      end
      if (state_r == ST_DONE && state_nxt == ST_IDLE) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      // sweep counter restarts on every state change
      if (state_nxt != state_r) begin
        sw_i_r  <= '0;
        sw_dv_r <= 1'b0;
      end else begin
        sw_dv_r <= sw_issue;
        if (sw_issue) begin
          sw_i_r <= sw_i_r + 1'b1;
        end
      end
      if (state_r == ST_UPD) begin
        if (nf_r == FRAME_W'(FRAME_COUNT - 1)) begin
          nf_r   <= '0;
          full_r <= 1'b1;
        end else begin
          nf_r <= nf_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    sw_di_r <= sw_i_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          va_r    <= in_virtual_address;
          hit_r   <= 1'b0;
          thit_r  <= 1'b0;
          fault_r <= 1'b0;
          evv_r   <= 1'b0;
          evp_r   <= '0;
          ins_r   <= 1'b0;
        end
      end
      ST_LOOK: begin
        if (tlb_hit) begin
          hit_r   <= 1'b1;
          frame_r <= tlb_frame;
        end else if (pt_q_r[FRAME_W]) begin
          thit_r  <= 1'b1;
          ins_r   <= 1'b1;
          frame_r <= pt_q_r[FRAME_W-1:0];
        end else begin
          fault_r <= 1'b1;
          ins_r   <= 1'b1;
          frame_r <= nf_r;
        end
      end
      ST_FMIN: begin
        if (sw_done) begin
          frame_r <= min_best[FRAME_W-1:0];
        end
      end
      ST_EVPT: begin
        evv_r <= 1'b1;
        evp_r <= ow_q_r;
      end
      ST_RWAIT: begin
        oldr_r <= rk_q_r;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_pa_r    <= pa32[TLBM_PA_W-1:0];
          out_hit_r   <= hit_r;
          out_thit_r  <= thit_r;
          out_fault_r <= fault_r;
          out_evv_r   <= evv_r;
          out_evp_r   <= evp32[TLBM_EVP_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pt_we) begin
      pt_mem[pt_wa] <= pt_wd;
    end
    pt_q_r <= pt_mem[pt_ra];
  end

  always_ff @(posedge clk) begin
    if (ow_we) begin
      ow_mem[frame_r] <= page_r;
    end
    ow_q_r <= ow_mem[frame_r];
  end

  always_ff @(posedge clk) begin
    if (rk_we) begin
      rk_mem[rk_wa] <= rk_wd;
    end
    rk_q_r <= rk_mem[rk_ra];
  end

  assign cfg_ready            = 1'b1;
  assign out_valid            = out_valid_r;
  assign out_physical_address = out_pa_r;
  assign out_tlb_hit          = out_hit_r;
  assign out_table_hit        = out_thit_r;
  assign out_page_fault       = out_fault_r;
  assign out_evicted_valid    = out_evv_r;
  assign out_evicted_page     = out_evp_r;

`ifndef SYNTH
  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot({out_tlb_hit, out_table_hit, out_page_fault}))
    else $error("result is not exactly one of hit, table hit, fault");

  a_evict_fault: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_evicted_valid) |-> out_page_fault)
    else $error("eviction reported without a fault");

  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second transaction taken while one is in flight");

  a_full_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    full_r |=> full_r)
    else $error("frames full flag dropped");

  a_evict_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EVPT) |-> full_r)
    else $error("eviction path entered with free frames left");
`endif

endmodule
